// ===== rtl/core/voxel_cube_frame_buffer_defines.svh =====
// Assertion macros shared by the frame buffer modules.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef VOXEL_CUBE_FRAME_BUFFER_DEFINES_SVH
`define VOXEL_CUBE_FRAME_BUFFER_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define VCFB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define VCFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VCFB_ASSERT_SAME(lbl, ante, cons, msg)
`define VCFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/vcfb_pkg.sv =====
package vcfb_pkg;

	// Layer address width and number of layer words held in the store.
	localparam int LW     = 3;
	localparam int LAYERS = 8;
	// One layer word, bit x+8y for voxel (x,y).
	localparam int WORD_W = 64;
	// Width of one coordinate.
	localparam int CW     = 3;

	// Command codes carried on func.
	typedef enum logic [1:0] {
		FN_BOX    = 2'd0,
		FN_MIRROR = 2'd1,
		FN_READ   = 2'd2,
		FN_UNUSED = 2'd3
	} func_t;

	// Write request into the layer store.
	typedef struct packed {
		logic              en;
		logic [LW-1:0]     addr;
		logic [WORD_W-1:0] data;
	} mem_wr_t;

endpackage

// ===== rtl/core/voxel_cube_frame_buffer.sv =====
// Channel | Handshake               | Beat payload
// --------+-------------------------+-----------------------------------------------
// in      | in_valid / in_stall     | func, box bounds, set_value, mirror_corner,
//         |                         | layer_index
// out     | out_valid / out_stall   | layer_bits, layer_select
//
// A box write stalls the input until its last layer word is written back: one layer
// word is read per cycle and written back in the cycle after, so the single read and
// write port of the layer store sets the pace. A mirror that flips x or y sweeps
// layers 0 to SIDE-1; a flip along z alone, an empty box and an unused code need no
// sweep. A layer read passes the read and then the output register, waiting while
// the latter is held by out_stall. Reset clears all control at once; the store holds
// one valid flop per layer, so it reads as dark immediately and needs no clearing pass.
`include "voxel_cube_frame_buffer_defines.svh"

module voxel_cube_frame_buffer
	import vcfb_pkg::*;
#(
	parameter int SIDE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [CW-1:0]     x_low,
	input  logic [CW-1:0]     y_low,
	input  logic [CW-1:0]     z_low,
	input  logic [CW-1:0]     x_high,
	input  logic [CW-1:0]     y_high,
	input  logic [CW-1:0]     z_high,
	input  logic              set_value,
	input  logic [CW-1:0]     mirror_corner,
	input  logic [LW-1:0]     layer_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] layer_bits,
	output logic [LAYERS-1:0] layer_select
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_RDOUT
	} state_t;

	// Highest coordinate inside the cube, and the cube side for range checks.
	localparam logic [CW-1:0] TOP_C  = CW'(SIDE - 1);
	localparam logic [CW:0]   SIDE_C = (CW + 1)'(SIDE);

	state_t            state_q;
	logic              op_box_q;
	logic              set_q;
	logic              fx_q;
	logic              fy_q;
	logic              flipz_q;
	logic [WORD_W-1:0] mask_q;
	logic [LW-1:0]     z_cur_q;
	logic [LW-1:0]     z_end_q;
	logic              rd_zero_q;
	logic [LW-1:0]     rd_idx_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] layer_bits_q;
	logic [LAYERS-1:0] layer_select_q;
	logic              wr_s1;
	logic [LW-1:0]     wr_addr_s1;

	logic              accept;
	logic [CW-1:0]     xh_c;
	logic [CW-1:0]     yh_c;
	logic [CW-1:0]     zh_c;
	logic              box_empty;
	logic              idx_ok;
	logic              rd_en;
	logic [LW-1:0]     rd_addr;
	logic [WORD_W-1:0] rword;
	logic [WORD_W-1:0] new_word;
	mem_wr_t           mem_wr;

	// Bit x+8y of the mask is set when (x,y) lies inside the box footprint.
	function automatic logic [WORD_W-1:0] box_mask(input logic [CW-1:0] xl,
		input logic [CW-1:0] xh, input logic [CW-1:0] yl, input logic [CW-1:0] yh);
		logic [WORD_W-1:0] m;
		logic [CW-1:0]     xs;
		logic [CW-1:0]     ys;
		m = '0;
		for (int y = 0; y < 8; y++) begin
			for (int x = 0; x < 8; x++) begin
				xs = CW'(x);
				ys = CW'(y);
				m[{ys, xs}] = (xs >= xl) && (xs <= xh) && (ys >= yl) && (ys <= yh);
			end
		end
		return m;
	endfunction

	// Mirrors one layer word within the cube along x and/or y.
	function automatic logic [WORD_W-1:0] xy_flip(input logic [WORD_W-1:0] w,
		input logic fx, input logic fy);
		logic [WORD_W-1:0] o;
		logic [CW-1:0]     xs;
		logic [CW-1:0]     ys;
		logic [CW-1:0]     dx;
		logic [CW-1:0]     dy;
		o = '0;
		for (int y = 0; y < SIDE; y++) begin
			for (int x = 0; x < SIDE; x++) begin
				xs = CW'(x);
				ys = CW'(y);
				dx = fx ? TOP_C - xs : xs;
				dy = fy ? TOP_C - ys : ys;
				o[{dy, dx}] = w[{ys, xs}];
			end
		end
		return o;
	endfunction

	// A flip along z is kept as an address swap rather than moving whole words.
	function automatic logic [LW-1:0] phys(input logic [LW-1:0] z, input logic flip);
		return flip ? TOP_C - z : z;
	endfunction

	assign accept   = in_valid && !in_stall;
	// The pending write-back must land before a new beat may read the store.
	assign in_stall = (state_q != ST_IDLE) || wr_s1;

	// High bounds past the cube edge are pulled back to the last voxel.
	assign xh_c      = (x_high > TOP_C) ? TOP_C : x_high;
	assign yh_c      = (y_high > TOP_C) ? TOP_C : y_high;
	assign zh_c      = (z_high > TOP_C) ? TOP_C : z_high;
	assign box_empty = (x_low > xh_c) || (y_low > yh_c) || (z_low > zh_c);
	assign idx_ok    = {1'b0, layer_index} < SIDE_C;

	// Read port: one layer per cycle while sweeping, or the requested scan-out layer.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = phys(z_cur_q, flipz_q);
		if (state_q == ST_BUSY) begin
			rd_en = 1'b1;
		end else if (accept && (func == FN_READ) && idx_ok) begin
			rd_en   = 1'b1;
			rd_addr = phys(layer_index, flipz_q);
		end
	end

	// Modify stage: the word read last cycle is updated and written back.
	assign new_word = op_box_q ? (set_q ? (rword | mask_q) : (rword & ~mask_q))
	                           : xy_flip(rword, fx_q, fy_q);

	assign mem_wr.en   = wr_s1;
	assign mem_wr.addr = wr_addr_s1;
	assign mem_wr.data = new_word;

	vcfb_layer_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rword),
		.wr      (mem_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_box_q       <= 1'b0;
			set_q          <= 1'b0;
			fx_q           <= 1'b0;
			fy_q           <= 1'b0;
			flipz_q        <= 1'b0;
			mask_q         <= '0;
			z_cur_q        <= '0;
			z_end_q        <= '0;
			rd_zero_q      <= 1'b0;
			rd_idx_q       <= '0;
			out_valid_q    <= 1'b0;
			layer_bits_q   <= '0;
			layer_select_q <= '0;
			wr_s1          <= 1'b0;
			wr_addr_s1     <= '0;
		end else begin
			wr_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func_t'(func))
							FN_BOX: begin
								if (!box_empty) begin
									op_box_q <= 1'b1;
									set_q    <= set_value;
									mask_q   <= box_mask(x_low, xh_c, y_low, yh_c);
									z_cur_q  <= z_low;
									z_end_q  <= zh_c;
									state_q  <= ST_BUSY;
								end
							end
							FN_MIRROR: begin
								if (mirror_corner[2]) begin
									flipz_q <= !flipz_q;
								end
								if (mirror_corner[0] || mirror_corner[1]) begin
									op_box_q <= 1'b0;
									fx_q     <= mirror_corner[0];
									fy_q     <= mirror_corner[1];
									z_cur_q  <= '0;
									z_end_q  <= TOP_C;
									state_q  <= ST_BUSY;
								end
							end
							FN_READ: begin
								rd_zero_q <= !idx_ok;
								rd_idx_q  <= layer_index;
								state_q   <= ST_RDOUT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_BUSY: begin
					wr_s1      <= 1'b1;
					wr_addr_s1 <= phys(z_cur_q, flipz_q);
					if (z_cur_q == z_end_q) begin
						state_q <= ST_IDLE;
					end else begin
						z_cur_q <= z_cur_q + 1'b1;
					end
				end
				ST_RDOUT: begin
					// The read data register holds until the output register frees up.
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						layer_bits_q   <= rd_zero_q ? '0 : rword;
						layer_select_q <= rd_zero_q ? '0 : (LAYERS'(1) << rd_idx_q);
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign layer_bits   = layer_bits_q;
	assign layer_select = layer_select_q;

	`VCFB_ASSERT_NEXT(a_read_goes_out, accept && (func == FN_READ), state_q == ST_RDOUT, "accepted layer read did not enter the output state")
	`VCFB_ASSERT_SAME(a_sweep_in_range, state_q == ST_BUSY, z_cur_q <= z_end_q, "layer sweep ran past its last layer")
	`VCFB_ASSERT_SAME(a_wb_blocks_input, wr_s1, in_stall, "input accepted while a write-back is pending")
	`VCFB_ASSERT_SAME(a_select_onehot, out_valid_q, $onehot0(layer_select_q), "layer select has more than one bit set")

endmodule

// ===== rtl/core/vcfb_layer_mem.sv =====
`include "voxel_cube_frame_buffer_defines.svh"

module vcfb_layer_mem
	import vcfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [LW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  mem_wr_t           wr
);

	logic [WORD_W-1:0] mem [LAYERS];
	logic [LAYERS-1:0] vld_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_vld_q;

	// Storage array, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// A layer never written since reset reads as dark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

	`VCFB_ASSERT_SAME(a_no_rw_collision, rd_en && wr.en, rd_addr != wr.addr, "read and write hit the same layer in one cycle")

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vcfb_pkg::*;

	// Cube edge length handed to the block. The predicted bounds and the layer range check
	// below are written in terms of it; the directed box coordinates are literal.
	localparam int SIDE = 8;

	// Cycles to let pass once nothing is expected any more. The slowest commands are a
	// mirror with a flip along x or y and a box over every layer, which sweep all layers.
	localparam int SETTLE_CYCLES = 4 * (SIDE + 1);

	// Length of the long output hold-off in the back-pressure test.
	localparam int HOLD_CYCLES = 300;

	// Generous ceiling on the whole run. The worst legal run is about a thousand commands,
	// each costing the block's own cycles plus long sender gaps and receiver stalls.
	localparam int CYCLE_LIMIT = 400000;

	// Only the first few mismatches are printed in full. Later ones are only counted.
	localparam int MAX_REPORTS = 10;

	// One command beat as the sender sees it. Every field is filled on every beat, so
	// the fields that a command ignores still carry random bits.
	typedef struct {
		func_t           fn;
		logic [CW-1:0]   xl;
		logic [CW-1:0]   yl;
		logic [CW-1:0]   zl;
		logic [CW-1:0]   xh;
		logic [CW-1:0]   yh;
		logic [CW-1:0]   zh;
		logic            setv;
		logic [CW-1:0]   corner;
		logic [LW-1:0]   layer;
	} voxel_cmd_t;

	// One scan-out beat that a layer read must produce.
	typedef struct {
		logic [WORD_W-1:0] bits;
		logic [LAYERS-1:0] sel;
	} layer_read_t;

	// The inputs start at known values: reset is held and no beat is offered.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        func = FN_UNUSED;
	logic [CW-1:0]     x_low = '0;
	logic [CW-1:0]     y_low = '0;
	logic [CW-1:0]     z_low = '0;
	logic [CW-1:0]     x_high = '0;
	logic [CW-1:0]     y_high = '0;
	logic [CW-1:0]     z_high = '0;
	logic              set_value = 1'b0;
	logic [CW-1:0]     mirror_corner = '0;
	logic [LW-1:0]     layer_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] layer_bits;
	logic [LAYERS-1:0] layer_select;

	// The testbench's own image of the cube, one word per layer with bit x+8y for voxel
	// (x,y). It follows every accepted command in acceptance order.
	logic [WORD_W-1:0] cube_image [LAYERS];

	// Scan-out beats still owed by the block, oldest first.
	layer_read_t reads_due [$];

	// Idling mix for the current phase, in percent of cycles.
	int idle_pct = 0;
	int stall_pct = 0;

	// The test raises hold_req at a falling edge. The stall process takes it at the next
	// rising edge and counts the hold-off down on its own.
	bit hold_req = 1'b0;
	int hold_cnt = 0;

	int cycle_cnt = 0;
	int fail_cnt = 0;
	int checked_cnt = 0;
	int box_cnt = 0;
	int mirror_cnt = 0;
	int read_cnt = 0;
	int unused_cnt = 0;

	voxel_cube_frame_buffer #(
		.SIDE(SIDE)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.x_low        (x_low),
		.y_low        (y_low),
		.z_low        (z_low),
		.x_high       (x_high),
		.y_high       (y_high),
		.z_high       (z_high),
		.set_value    (set_value),
		.mirror_corner(mirror_corner),
		.layer_index  (layer_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.layer_bits   (layer_bits),
		.layer_select (layer_select)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The cycle counter doubles as the watchdog. A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d layer reads outstanding.",
				cycle_cnt, reads_due.size());
			$display("FAIL");
			$finish;
		end
	end

	// Receiver side. A requested hold-off keeps out_stall high until hold_cnt runs out.
	// Otherwise the stall is drawn afresh every cycle from the current phase's mix.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Scan-out checker. Every accepted output beat is matched against the oldest owed
	// read. All samples are taken just after the edge, so they hold the values that the
	// edge itself saw.
	always @(posedge clk) begin
		layer_read_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reads_due.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= MAX_REPORTS)
					$display("%0t: output beat with no read pending: bits %h select %b",
						$realtime, layer_bits, layer_select);
			end else begin
				want = reads_due.pop_front();
				checked_cnt++;
				if (layer_bits !== want.bits || layer_select !== want.sel) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display({"%0t: layer read mismatch: expected bits %h select %b,",
							" got bits %h select %b"},
							$realtime, want.bits, want.sel, layer_bits, layer_select);
				end
			end
		end
	end

	// Advances the cube image by one accepted command and records the scan-out beat that
	// a layer read owes.
	function automatic void apply_command(input voxel_cmd_t c);
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] flipped [LAYERS];
		layer_read_t       owed;
		int                xh, yh, zh, dx, dy, dz;
		case (c.fn)
			FN_BOX: begin
				box_cnt++;
				// High bounds past the cube are pulled back to its last row. A low bound
				// above its high bound leaves that axis empty, so its loop never runs.
				xh = (int'(c.xh) > SIDE - 1) ? SIDE - 1 : int'(c.xh);
				yh = (int'(c.yh) > SIDE - 1) ? SIDE - 1 : int'(c.yh);
				zh = (int'(c.zh) > SIDE - 1) ? SIDE - 1 : int'(c.zh);
				mask = '0;
				for (int y = c.yl; y <= yh; y++)
					for (int x = c.xl; x <= xh; x++)
						mask[x + 8 * y] = 1'b1;
				for (int z = c.zl; z <= zh; z++)
					cube_image[z] = c.setv ? (cube_image[z] | mask) : (cube_image[z] & ~mask);
			end
			FN_MIRROR: begin
				mirror_cnt++;
				foreach (flipped[i])
					flipped[i] = '0;
				for (int z = 0; z < SIDE; z++)
					for (int y = 0; y < SIDE; y++)
						for (int x = 0; x < SIDE; x++) begin
							dx = c.corner[0] ? SIDE - 1 - x : x;
							dy = c.corner[1] ? SIDE - 1 - y : y;
							dz = c.corner[2] ? SIDE - 1 - z : z;
							if (cube_image[z][x + 8 * y])
								flipped[dz][dx + 8 * dy] = 1'b1;
						end
				cube_image = flipped;
			end
			FN_READ: begin
				read_cnt++;
				// A layer past the cube still answers, with both fields dark.
				if (int'(c.layer) < SIDE) begin
					owed.bits = cube_image[c.layer];
					owed.sel = LAYERS'(1) << c.layer;
				end else begin
					owed.bits = '0;
					owed.sel = '0;
				end
				reads_due.push_back(owed);
			end
			default: begin
				unused_cnt++;
			end
		endcase
	endfunction

	// Fills every field with random bits. The directed helpers then overwrite the fields
	// that matter for their command.
	function automatic voxel_cmd_t noise_cmd(input func_t fn);
		voxel_cmd_t c;
		c.fn = fn;
		c.xl = CW'($urandom);
		c.yl = CW'($urandom);
		c.zl = CW'($urandom);
		c.xh = CW'($urandom);
		c.yh = CW'($urandom);
		c.zh = CW'($urandom);
		c.setv = 1'($urandom);
		c.corner = CW'($urandom);
		c.layer = LW'($urandom);
		return c;
	endfunction

	// Offers one beat and returns in the time step of its acceptance. Valid stays high
	// afterwards, so that a following beat with no gap goes out on the next cycle. A gap
	// lowers valid first, in a later time step than the one that raised it.
	task automatic send_cmd(input voxel_cmd_t c);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		func <= c.fn;
		x_low <= c.xl;
		y_low <= c.yl;
		z_low <= c.zl;
		x_high <= c.xh;
		y_high <= c.yh;
		z_high <= c.zh;
		set_value <= c.setv;
		mirror_corner <= c.corner;
		layer_index <= c.layer;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_command(c);
	endtask

	task automatic send_box(input int xl, input int yl, input int zl,
			input int xh, input int yh, input int zh, input bit setv);
		voxel_cmd_t c;
		c = noise_cmd(FN_BOX);
		c.xl = CW'(xl);
		c.yl = CW'(yl);
		c.zl = CW'(zl);
		c.xh = CW'(xh);
		c.yh = CW'(yh);
		c.zh = CW'(zh);
		c.setv = setv;
		send_cmd(c);
	endtask

	task automatic send_mirror(input int corner);
		voxel_cmd_t c;
		c = noise_cmd(FN_MIRROR);
		c.corner = CW'(corner);
		send_cmd(c);
	endtask

	task automatic send_read(input int layer);
		voxel_cmd_t c;
		c = noise_cmd(FN_READ);
		c.layer = LW'(layer);
		send_cmd(c);
	endtask

	// Drops valid and waits until every owed read has come back. Then it lets the block
	// finish any write or mirror still running behind the last read.
	task automatic wait_for_reads();
		in_valid <= 1'b0;
		while (reads_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// After reset the first and the last layer must read dark, each with its matching one-hot select.
	task automatic test_reset_state();
		send_read(0);
		send_read(SIDE - 1);
	endtask

	// Box writes at the extremes: a full fill, a single voxel carved out of it, boxes empty
	// along each axis in turn, a full clear, single voxels at both corners, and a small box.
	task automatic test_box_writes();
		send_box(0, 0, 0, 7, 7, 7, 1'b1);
		send_read(5);
		send_box(3, 4, 5, 3, 4, 5, 1'b0);
		send_read(5);
		send_box(5, 0, 0, 2, 7, 7, 1'b0);
		send_box(0, 6, 0, 7, 1, 7, 1'b0);
		send_box(0, 0, 7, 7, 7, 0, 1'b0);
		send_read(5);
		send_box(0, 0, 0, 7, 7, 7, 1'b0);
		send_box(0, 0, 0, 0, 0, 0, 1'b1);
		send_box(7, 7, 7, 7, 7, 7, 1'b1);
		send_box(1, 2, 0, 5, 3, 1, 1'b1);
	endtask

	// Flips along no axis, each single axis, and all three at once. The cube is lopsided
	// from the box test, so every flip along an axis moves some voxels.
	task automatic test_mirrors();
		send_mirror(0);
		send_mirror(1);
		send_mirror(2);
		send_mirror(4);
		send_read(0);
		send_mirror(7);
		send_read(0);
		send_read(7);
	endtask

	// The spare func code must change nothing and answer nothing.
	task automatic test_unused_code();
		voxel_cmd_t c;
		c = noise_cmd(FN_UNUSED);
		send_cmd(c);
		send_read(7);
	endtask

	// Random traffic under one idling mix. Most boxes are well formed, so that they
	// really draw into the cube. The rest keep random bound order and can come out empty.
	// Spare codes are sprinkled in, but they do not count toward the beat total.
	task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
			input int beats);
		voxel_cmd_t c;
		logic [CW-1:0] swap;
		int pick;
		int done;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		done = 0;
		while (done < beats) begin
			pick = $urandom_range(99);
			if (pick < 40)
				c = noise_cmd(FN_BOX);
			else if (pick < 55)
				c = noise_cmd(FN_MIRROR);
			else if (pick < 95)
				c = noise_cmd(FN_READ);
			else
				c = noise_cmd(FN_UNUSED);
			if (c.fn == FN_BOX && $urandom_range(99) < 85) begin
				if (c.xl > c.xh) begin
					swap = c.xl;
					c.xl = c.xh;
					c.xh = swap;
				end
				if (c.yl > c.yh) begin
					swap = c.yl;
					c.yl = c.yh;
					c.yh = swap;
				end
				if (c.zl > c.zh) begin
					swap = c.zl;
					c.zl = c.zh;
					c.zh = swap;
				end
			end
			send_cmd(c);
			if (c.fn != FN_UNUSED)
				done++;
		end
		wait_for_reads();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering reads and
	// writes back to back. The output register fills up and the block has to stall its
	// input. Once the hold-off ends, everything must drain in order.
	task automatic test_output_hold();
		idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		for (int i = 0; i < 24; i++) begin
			if (i % 3 == 2)
				send_box($urandom_range(7), $urandom_range(7), 0, 7, 7, 7, 1'($urandom));
			else
				send_read($urandom_range(SIDE - 1));
		end
		wait_for_reads();
	endtask

	initial begin
		foreach (cube_image[i])
			cube_image[i] = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		test_reset_state();
		test_box_writes();
		test_mirrors();
		test_unused_code();
		wait_for_reads();

		// Four idling mixes: none, a slow sender, a slow receiver, and a light mix of both.
		test_random_traffic(0, 0, 200);
		test_random_traffic(75, 0, 200);
		test_random_traffic(0, 75, 200);
		test_random_traffic(14, 14, 200);

		test_output_hold();

		$display("Sent %0d box writes, %0d mirrors, %0d layer reads and %0d spare codes.",
			box_cnt, mirror_cnt, read_cnt, unused_cnt);
		$display("Checked %0d scan-out beats under four idling mixes and a %0d-cycle hold-off.",
			checked_cnt, HOLD_CYCLES);
		if (fail_cnt == 0 && reads_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d failures, %0d reads still owed.", fail_cnt, reads_due.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
